>>> rtl/serial_frame_receiver_assert.svh
// assertion macros for the serial frame receiver
// used by serial_frame_receiver.sv, no other dependencies
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define SFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/sfr_pkg.sv
// types and constants shared by the serial frame receiver
// no dependencies
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int FRAME_BYTES  = 100;
    localparam int HEADER_BYTES = 5;
    localparam int POS_W        = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] FRAME_LIMIT = POS_W'(FRAME_BYTES - HEADER_BYTES);

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_TOKEN = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       is_start;
        logic       is_token;
        logic       is_end;
    } t_cls;

    typedef struct packed {
        logic       store_valid;
        logic [6:0] store_offset;
        logic [7:0] store_value;
        logic       frame_done;
        logic [7:0] frame_address;
        logic [7:0] frame_sequence;
        logic [7:0] frame_payload_len;
        logic [6:0] frame_total_len;
    } t_result;

endpackage

>>> rtl/sfr_rx_if.sv
// received byte channel: valid, ready and one byte per beat
// no dependencies
`timescale 1ns / 1ps

interface sfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/sfr_res_if.sv
// result channel: store report and frame completion fields per beat
// no dependencies
`timescale 1ns / 1ps

interface sfr_res_if;
    logic       valid;
    logic       ready;
    logic       store_valid;
    logic [6:0] store_offset;
    logic [7:0] store_value;
    logic       frame_done;
    logic [7:0] frame_address;
    logic [7:0] frame_sequence;
    logic [7:0] frame_payload_len;
    logic [6:0] frame_total_len;

    modport source (
        output valid, output store_valid, output store_offset, output store_value,
        output frame_done, output frame_address, output frame_sequence,
        output frame_payload_len, output frame_total_len, input ready
    );
    modport sink (
        input valid, input store_valid, input store_offset, input store_value,
        input frame_done, input frame_address, input frame_sequence,
        input frame_payload_len, input frame_total_len, output ready
    );
endinterface

>>> rtl/sfr_front.sv
// front end: marker registers and per-byte marker compare
// depends on sfr_pkg and sfr_rx_if
`timescale 1ns / 1ps

module sfr_front
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfr_rx_if.sink      i_rx,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_full,
    output logic        o_push,
    output t_cls        o_item,
    output logic [7:0]  o_start_marker
);

    logic [7:0] r_start_marker;
    logic [7:0] r_token_marker;
    logic [7:0] r_end_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_token_marker <= '0;
            r_end_marker   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START: r_start_marker <= i_cfg_data;
                CFG_TOKEN: r_token_marker <= i_cfg_data;
                CFG_END:   r_end_marker   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_rx.ready = !i_full;
    assign o_push     = i_rx.valid && !i_full;

    always_comb begin
        o_item.data     = i_rx.rx_byte;
        o_item.is_start = (i_rx.rx_byte == r_start_marker);
        o_item.is_token = (i_rx.rx_byte == r_token_marker);
        o_item.is_end   = (i_rx.rx_byte == r_end_marker);
    end

    assign o_start_marker = r_start_marker;

endmodule

>>> rtl/sfr_queue.sv
// short queue of classified bytes between front and back
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_queue
    import sfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cls  i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_cls  o_item
);

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/sfr_back.sv
// back end: frame parser state machine and result register
// depends on sfr_pkg and sfr_res_if
`timescale 1ns / 1ps

module sfr_back
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cls        i_item,
    input  logic [7:0]  i_start_marker,
    output logic        o_pop,
    sfr_res_if.source   o_res
);

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_ADDR   = 4'd1,
        PH_INDEX  = 4'd2,
        PH_SIZE   = 4'd3,
        PH_TOKEN  = 4'd4,
        PH_DATA   = 4'd5,
        PH_CHK_LO = 4'd6,
        PH_CHK_HI = 4'd7,
        PH_END    = 4'd8
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_left, n_left;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_len, n_len;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic [POS_W-1:0] w_pos_inc;
    logic [7:0]       w_left_dec;

    assign o_pop      = !i_empty && (!r_out_valid || o_res.ready);
    assign w_pos_inc  = r_pos + 1'b1;
    assign w_left_dec = r_left - 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_left      = r_left;
        n_addr      = r_addr;
        n_seq       = r_seq;
        n_len       = r_len;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            // stored byte at the current offset unless a phase below overrides
            n_out.store_valid  = 1'b1;
            n_out.store_offset = r_pos[6:0];
            n_out.store_value  = i_item.data;
            n_pos              = w_pos_inc;
            case (r_phase)
                PH_START: begin
                    n_out.store_offset = '0;
                    n_out.store_value  = i_start_marker;
                    n_pos              = POS_W'(1);
                    if (i_item.is_start) begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    n_addr  = i_item.data;
                    n_phase = PH_INDEX;
                end
                PH_INDEX: begin
                    n_seq   = i_item.data;
                    n_phase = PH_SIZE;
                end
                PH_SIZE: begin
                    n_len   = i_item.data;
                    n_left  = i_item.data;
                    n_phase = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (i_item.is_token) begin
                        n_phase = (r_left != '0) ? PH_DATA : PH_CHK_LO;
                    end else begin
                        n_out   = '0;
                        n_pos   = r_pos;
                        n_phase = PH_START;
                    end
                end
                PH_DATA: begin
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_phase = PH_CHK_LO;
                    end
                    // payload overruns the frame image
                    if (w_pos_inc > FRAME_LIMIT) begin
                        n_phase = PH_START;
                    end
                end
                PH_CHK_LO: begin
                    n_phase = PH_CHK_HI;
                end
                PH_CHK_HI: begin
                    n_phase = PH_END;
                end
                PH_END: begin
                    n_phase = PH_START;
                    if (i_item.is_end) begin
                        n_out.frame_done        = 1'b1;
                        n_out.frame_address     = r_addr;
                        n_out.frame_sequence    = r_seq;
                        n_out.frame_payload_len = r_len;
                        n_out.frame_total_len   = w_pos_inc[6:0];
                    end
                end
                default: begin
                    n_out   = '0;
                    n_pos   = r_pos;
                    n_phase = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_pos       <= '0;
            r_left      <= '0;
            r_addr      <= '0;
            r_seq       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_left      <= n_left;
            r_addr      <= n_addr;
            r_seq       <= n_seq;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.store_valid       = r_out.store_valid;
    assign o_res.store_offset      = r_out.store_offset;
    assign o_res.store_value       = r_out.store_value;
    assign o_res.frame_done        = r_out.frame_done;
    assign o_res.frame_address     = r_out.frame_address;
    assign o_res.frame_sequence    = r_out.frame_sequence;
    assign o_res.frame_payload_len = r_out.frame_payload_len;
    assign o_res.frame_total_len   = r_out.frame_total_len;

endmodule

>>> rtl/serial_frame_receiver.sv
// top level of the serial frame receiver: front, queue and back
// depends on sfr_pkg, sfr_rx_if, sfr_res_if, sfr_front, sfr_queue, sfr_back
// and serial_frame_receiver_assert.svh
//
// channel   dir  beat
// i_rx      in   rx_byte, one received byte
// o_res     out  store report and frame completion fields, one per byte
// cfg       in   i_cfg_we / i_cfg_index / i_cfg_data, marker writes
//
// one byte per cycle sustained while the result side is ready; each byte gives one result beat.
// an accepted byte passes through the byte queue and then the result register.
// while a result stalls the four-entry byte queue takes up to four more beats, then ready drops.
// synchronous active-low reset clears parser state, queue and markers.
`timescale 1ns / 1ps
`include "serial_frame_receiver_assert.svh"

module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfr_rx_if.sink      i_rx,
    sfr_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic       w_full;
    logic       w_empty;
    logic       w_push;
    logic       w_pop;
    t_cls       w_push_item;
    t_cls       w_pop_item;
    logic [7:0] w_start_marker;

    sfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx           (i_rx),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_item         (w_push_item),
        .o_start_marker (w_start_marker)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    sfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_item         (w_pop_item),
        .i_start_marker (w_start_marker),
        .o_pop          (w_pop),
        .o_res          (o_res)
    );

    `SFR_ASSERT_IMP(a_done_stores, i_clk, i_rst_n, o_res.valid && o_res.frame_done, o_res.store_valid, "frame done without stored end byte")
    `SFR_ASSERT_IMP(a_done_len, i_clk, i_rst_n, o_res.valid && o_res.frame_done, o_res.frame_total_len == o_res.store_offset + 7'd1, "frame length does not match end offset")
    `SFR_ASSERT_IMP(a_nostore_zero, i_clk, i_rst_n, o_res.valid && !o_res.store_valid, o_res.store_offset == 7'd0 && o_res.store_value == 8'd0 && !o_res.frame_done, "idle result carries data")
    `SFR_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_res.valid && o_res.ready && o_res.frame_done, !(o_res.valid && o_res.frame_done), "two frame done beats in a row")

endmodule

>>> tb/sv/sfr_checker.sv
// checker for the serial frame receiver: tracks marker writes, predicts each result beat
// from the accepted bytes and compares it with the result channel
// depends on sfr_pkg, sfr_rx_if and sfr_res_if
`timescale 1ns / 1ps

module sfr_checker
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfr_rx_if           i_rx,
    sfr_res_if          i_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_ADDR,
        PH_INDEX,
        PH_LENGTH,
        PH_TOKEN,
        PH_PAYLOAD,
        PH_CHECK_LO,
        PH_CHECK_HI,
        PH_CLOSE
    } frame_phase_e;

    logic [7:0]       start_byte;
    logic [7:0]       token_byte;
    logic [7:0]       end_byte;

    frame_phase_e     phase;
    logic [POS_W-1:0] frame_pos;
    logic [7:0]       payload_left;
    logic [7:0]       held_addr;
    logic [7:0]       held_seq;
    logic [7:0]       held_len;

    t_result          expected_reports [$];
    int               errors_seen  = 0;
    int               pending_cnt  = 0;

    assign o_errors  = errors_seen;
    assign o_pending = pending_cnt;

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result          r;
        logic             store;
        logic [POS_W-1:0] off;
        logic [7:0]       val;
        logic             done;
        r     = '0;
        store = 1'b0;
        off   = '0;
        val   = '0;
        done  = 1'b0;
        case (phase)
            PH_HUNT: begin
                // the start marker is written at offset zero on every hunted byte
                store     = 1'b1;
                val       = start_byte;
                frame_pos = POS_W'(1);
                if (b == start_byte) phase = PH_ADDR;
            end
            PH_ADDR, PH_INDEX, PH_LENGTH, PH_PAYLOAD, PH_CHECK_LO, PH_CHECK_HI,
            PH_CLOSE: begin
                store     = 1'b1;
                off       = frame_pos;
                val       = b;
                frame_pos = frame_pos + 1'b1;
                case (phase)
                    PH_ADDR: begin
                        held_addr = b;
                        phase     = PH_INDEX;
                    end
                    PH_INDEX: begin
                        held_seq = b;
                        phase    = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        held_len     = b;
                        payload_left = b;
                        phase        = PH_TOKEN;
                    end
                    PH_PAYLOAD: begin
                        payload_left = payload_left - 1'b1;
                        if (payload_left == 0) phase = PH_CHECK_LO;
                        if (int'(frame_pos) + HEADER_BYTES > FRAME_BYTES) phase = PH_HUNT;
                    end
                    PH_CHECK_LO: phase = PH_CHECK_HI;
                    PH_CHECK_HI: phase = PH_CLOSE;
                    default: begin
                        phase = PH_HUNT;
                        done  = (b == end_byte);
                    end
                endcase
            end
            PH_TOKEN: begin
                if (b == token_byte) begin
                    store     = 1'b1;
                    off       = frame_pos;
                    val       = b;
                    frame_pos = frame_pos + 1'b1;
                    phase     = (payload_left != 0) ? PH_PAYLOAD : PH_CHECK_LO;
                end else begin
                    phase = PH_HUNT;
                end
            end
            default: phase = PH_HUNT;
        endcase
        if (store) begin
            r.store_valid  = 1'b1;
            r.store_offset = off[6:0];
            r.store_value  = val;
        end
        if (done) begin
            r.frame_done        = 1'b1;
            r.frame_address     = held_addr;
            r.frame_sequence    = held_seq;
            r.frame_payload_len = held_len;
            r.frame_total_len   = frame_pos[6:0];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors_seen++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            start_byte   = '0;
            token_byte   = '0;
            end_byte     = '0;
            phase        = PH_HUNT;
            frame_pos    = '0;
            payload_left = '0;
            held_addr    = '0;
            held_seq     = '0;
            held_len     = '0;
            expected_reports.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_reports.size() == 0) begin
                    errors_seen++;
                    $display("%0t: result beat with nothing expected, actual offset 0x%0h",
                             $time, i_res.store_offset);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("store_valid", want.store_valid, i_res.store_valid);
                    check_field("store_offset", want.store_offset, i_res.store_offset);
                    check_field("store_value", want.store_value, i_res.store_value);
                    check_field("frame_done", want.frame_done, i_res.frame_done);
                    check_field("frame_address", want.frame_address, i_res.frame_address);
                    check_field("frame_sequence", want.frame_sequence, i_res.frame_sequence);
                    check_field("frame_payload_len", want.frame_payload_len,
                                i_res.frame_payload_len);
                    check_field("frame_total_len", want.frame_total_len,
                                i_res.frame_total_len);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START: start_byte = i_cfg_data;
                    CFG_TOKEN: token_byte = i_cfg_data;
                    CFG_END:   end_byte   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) expected_reports.push_back(parse_byte(i_rx.rx_byte));
        end
        pending_cnt = expected_reports.size();
    end

endmodule

>>> tb/sv/testbench.sv
// top of the serial frame receiver testbench: clock, reset, marker writes and byte stimulus
// with random gaps on both channels; verdict from the checker's failure count
// depends on sfr_pkg, sfr_rx_if, sfr_res_if, sfr_checker and serial_frame_receiver
`timescale 1ns / 1ps

module testbench;
    import sfr_pkg::*;

    localparam int           RANDOM_BEATS   = 1300;
    localparam int           TIMEOUT_CYCLES = 400000;
    localparam int           HOLD_CYCLES    = 120;
    localparam int           PAYLOAD_ROOM   = FRAME_BYTES - 2 * HEADER_BYTES;
    localparam logic [1:0]   CFG_UNUSED     = 2'd3;
    localparam logic [7:0]   START0         = 8'hA5;
    localparam logic [7:0]   TOKEN0         = 8'h3C;
    localparam logic [7:0]   END0           = 8'h7E;
    localparam logic [7:0]   DIRECTED [25]  = '{
        8'h00, 8'hFF,
        START0, 8'h00, 8'hFF, 8'h00, TOKEN0, 8'h00, 8'hFF, END0,
        START0, 8'h12, 8'h34, 8'h01, ~TOKEN0,
        START0, 8'hFF, 8'h00, 8'h02, TOKEN0, 8'h00, 8'hFF, 8'h12, 8'h34, ~END0
    };

    typedef enum int {
        FR_GOOD,
        FR_BAD_TOKEN,
        FR_BAD_END,
        FR_OVERSIZE,
        FR_ABANDON,
        FR_NOISE
    } frame_kind_e;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    logic [7:0] start_byte;
    logic [7:0] token_byte;
    logic [7:0] end_byte;
    bit         tx_gaps_on;
    bit         rx_gaps_on;
    bit         hold_req;
    int         bytes_sent;
    int         error_count;
    int         pending_beats;

    sfr_rx_if  rx_ch ();
    sfr_res_if res_ch ();

    serial_frame_receiver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sfr_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .i_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (error_count),
        .o_pending   (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 9) < 3) begin
                stall_left = pick_gap() - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (tx_gaps_on && $urandom_range(0, 9) < 3) begin
            gap = pick_gap();
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_beats != 0) @(negedge i_clk);
    endtask

    task automatic program_markers(input logic [7:0] s, input logic [7:0] t,
                                   input logic [7:0] e, input bit poke_unused);
        drain();
        repeat (2) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START;
        cfg_data  <= s;
        @(negedge i_clk);
        cfg_index <= CFG_TOKEN;
        cfg_data  <= t;
        @(negedge i_clk);
        cfg_index <= CFG_END;
        cfg_data  <= e;
        if (poke_unused) begin
            @(negedge i_clk);
            cfg_index <= CFG_UNUSED;
            cfg_data  <= 8'($urandom);
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        start_byte = s;
        token_byte = t;
        end_byte   = e;
    endtask

    function automatic frame_kind_e pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return FR_GOOD;
        if (r < 68) return FR_BAD_TOKEN;
        if (r < 78) return FR_BAD_END;
        if (r < 80) return FR_OVERSIZE;
        if (r < 88) return FR_ABANDON;
        return FR_NOISE;
    endfunction

    task automatic send_frame(input frame_kind_e kind);
        logic [7:0] len;
        int         r;
        int         n;
        r = $urandom_range(0, 99);
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            return;
        end
        send_byte(start_byte);
        if (kind == FR_ABANDON) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            return;
        end
        if (kind == FR_OVERSIZE) len = (r < 30) ? 8'(PAYLOAD_ROOM + 1)
                                                : 8'($urandom_range(PAYLOAD_ROOM + 1, 255));
        else if (r < 70) len = 8'($urandom_range(0, 8));
        else if (r < 90) len = 8'($urandom_range(9, 40));
        else len = 8'($urandom_range(PAYLOAD_ROOM - 5, PAYLOAD_ROOM));
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(len);
        if (kind == FR_BAD_TOKEN) begin
            send_byte(token_byte ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(token_byte);
        // an oversized frame is abandoned after one byte past the room; the byte after it is hunted
        n = (int'(len) > PAYLOAD_ROOM) ? PAYLOAD_ROOM + 2 : int'(len);
        repeat (n) send_byte(8'($urandom));
        if (int'(len) > PAYLOAD_ROOM) return;
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        if (kind == FR_BAD_END) send_byte(end_byte ^ 8'($urandom_range(1, 255)));
        else send_byte(end_byte);
    endtask

    task automatic run_random(input int beats, input bit with_hold, input bit with_pause);
        int target;
        target = bytes_sent + beats;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 19) == 0) begin
                tx_gaps_on = $urandom_range(0, 3) != 0;
                rx_gaps_on = $urandom_range(0, 3) != 0;
            end
            if (with_hold && bytes_sent >= target - beats / 2) begin
                // sender keeps offering while the result side holds off
                with_hold  = 1'b0;
                tx_gaps_on = 1'b0;
                hold_req   = 1'b1;
            end
            if (with_pause && bytes_sent >= target - beats / 2) begin
                with_pause = 1'b0;
                drain();
            end
            send_frame(pick_kind());
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START;
        cfg_data      = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        start_byte    = '0;
        token_byte    = '0;
        end_byte      = '0;
        tx_gaps_on    = 1'b1;
        rx_gaps_on    = 1'b1;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        program_markers(START0, TOKEN0, END0, 1'b1);
        foreach (DIRECTED[k]) send_byte(DIRECTED[k]);

        run_random(RANDOM_BEATS / 4, 1'b1, 1'b0);
        program_markers(8'h00, 8'hFF, 8'h00, 1'b0);
        run_random(RANDOM_BEATS / 4, 1'b0, 1'b1);
        program_markers(8'hFF, 8'h00, 8'hFF, 1'b1);
        run_random(RANDOM_BEATS / 4, 1'b0, 1'b0);
        program_markers(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        run_random(RANDOM_BEATS / 4, 1'b0, 1'b0);

        drain();
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
